@@ rtl/rcpd_pkg.sv @@
// Shared types and constants for the radio code packet deframer.
package rcpd_pkg;

    // Field widths
    localparam int CODE_W = 24;
    localparam int LEN_W  = 5;
    localparam int CFG_W  = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

    // Configuration reset values
    localparam logic [7:0]       SYNC_RESET    = 8'hAA;
    localparam logic [15:0]      TIMEOUT_RESET = 16'd1000;
    localparam logic [LEN_W-1:0] MAXLEN_RESET  = 5'd16;

    // CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_CRC_FAIL = 2'd1;
    localparam logic [1:0] STAT_BAD_LEN  = 2'd2;
    localparam logic [1:0] STAT_TIMEOUT  = 2'd3;

    // Frame phase
    typedef enum logic [1:0] {
        PH_SYNC,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    // Control sequencer
    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SYNC2,
        FS_PAY,
        FS_CHECK,
        FS_RESULT,
        FS_READ,
        FS_EMIT
    } t_fsm;

    // Input item
    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] code;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       seq_number;
        logic [7:0]       frame_kind;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       data_byte;
        logic [7:0]       computed_crc;
        logic             last_item;
    } t_out_item;

    // Pending single result (timeout, bad length, crc failure, empty packet)
    typedef struct packed {
        logic [1:0]       status;
        logic [LEN_W-1:0] length;
        logic [7:0]       crc;
    } t_res;

endpackage

@@ rtl/rcpd_payload_mem.sv @@
// Payload byte store: one write port, one read port with registered read data.
module rcpd_payload_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/rf_code_packet_deframer.sv @@
// Radio code packet deframer: sync / header / payload framing with CRC-8 check.
//
// Items are radio codes (func 0) or millisecond ticks (func 1). A tick that
// does not time out, an ignored code, a header code that opens a payload or a
// payload code that does not finish the frame produces no result; a sync code
// keeps the input stalled while the second CRC byte is folded in. A payload
// code passes each byte in turn through the single CRC-8 byte unit and the
// payload memory write port (FS_PAY), then the frame check (FS_CHECK). A good
// packet then reads its bytes back from the payload memory, each result going
// through a memory read (FS_READ), then the output register (FS_EMIT).
// Failures, bad lengths, empty packets and timeouts produce one
// result. An item is accepted while a finished result still sits in the
// output register; the sequencer waits only when it has a new result to load.
// The payload memory needs no clearing: a byte is read only after it was
// written for the current packet.
module rf_code_packet_deframer #(
    parameter int MAX_LEN = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rcpd_pkg::t_in_item    i_in_item,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rcpd_pkg::t_out_item   o_out_item,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rcpd_pkg::CFG_W-1:0]     i_cfg_data
);

    import rcpd_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = (AW > LEN_W) ? AW : LEN_W;
    localparam logic [7:0] MaxLen8 = 8'(MAX_LEN);
    localparam logic [1:0] LAST_BYTE = 2'd2;

    // One CRC-8 byte step, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Configuration registers
    logic [7:0]       r_sync_value;
    logic [15:0]      r_timeout;
    logic [LEN_W-1:0] r_max_len;

    // Frame state
    t_fsm             r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [CODE_W-1:0] r_last_code, n_last_code;
    logic [15:0]      r_elapsed, n_elapsed;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_kind, n_kind;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_rcrc, n_rcrc;
    logic [7:0]       r_crc, n_crc;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_idx, n_idx;
    logic [1:0]       r_sel, n_sel;
    logic [CODE_W-1:0] r_code, n_code;
    t_res             r_res, n_res;

    // Output register
    logic             r_out_valid;
    t_out_item        r_out_item, n_out_item;
    logic             out_load;
    logic             out_free;

    // Datapath helpers
    logic             in_accept;
    logic [7:0]       b0, b1, b2;
    logic [7:0]       limit;
    logic [15:0]      elapsed_inc;
    logic [CW-1:0]    len_ext;
    logic [7:0]       pay_byte;
    logic [7:0]       crc_in, crc_data, crc_out;
    logic             last_out;
    logic             wr_en, rd_en;
    logic [7:0]       rd_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != FS_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign b0 = i_in_item.code[23:16];
    assign b1 = i_in_item.code[15:8];
    assign b2 = i_in_item.code[7:0];

    // Accepted length limit: smaller of the register and the store depth
    assign limit = ({3'b000, r_max_len} < MaxLen8) ? {3'b000, r_max_len} : MaxLen8;

    assign elapsed_inc = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign len_ext     = CW'(r_len);
    assign last_out    = ((r_idx + CW'(1)) == len_ext);

    // Payload byte of the buffered code
    always_comb begin
        unique case (r_sel)
            2'd0:    pay_byte = r_code[23:16];
            2'd1:    pay_byte = r_code[15:8];
            default: pay_byte = r_code[7:0];
        endcase
    end

    // Shared CRC byte unit operand select
    always_comb begin
        crc_in   = r_crc;
        crc_data = pay_byte;
        unique case (r_state)
            FS_IDLE: begin
                if (r_phase == PH_HEADER) begin
                    crc_data = b0;
                end else begin
                    crc_in   = 8'h00;
                    crc_data = b1;
                end
            end
            FS_SYNC2: crc_data = r_code[7:0];
            default:  crc_data = pay_byte;
        endcase
    end

    assign crc_out = crc8_step(crc_in, crc_data);

    // Payload memory
    rcpd_payload_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_payload_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (pay_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Sequencer: next state, frame state and result
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_last_code = r_last_code;
        n_elapsed   = r_elapsed;
        n_seq       = r_seq;
        n_kind      = r_kind;
        n_len       = r_len;
        n_rcrc      = r_rcrc;
        n_crc       = r_crc;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_sel       = r_sel;
        n_code      = r_code;
        n_res       = r_res;
        n_out_item  = r_out_item;
        out_load    = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;

        unique case (r_state)
            FS_IDLE: begin
                if (in_accept) begin
                    if (i_in_item.func) begin
                        // millisecond tick
                        n_elapsed = elapsed_inc;
                        if (r_phase != PH_SYNC && elapsed_inc > r_timeout) begin
                            n_res.status = STAT_TIMEOUT;
                            n_res.length = (r_phase == PH_PAYLOAD) ? r_len : '0;
                            n_res.crc    = 8'h00;
                            n_phase      = PH_SYNC;
                            n_last_code  = '0;
                            n_state      = FS_RESULT;
                        end
                    end else if (i_in_item.code != '0 && i_in_item.code != r_last_code) begin
                        n_last_code = i_in_item.code;
                        n_elapsed   = 16'd0;
                        unique case (r_phase)
                            PH_HEADER: begin
                                if (b0 > limit) begin
                                    n_res.status = STAT_BAD_LEN;
                                    n_res.length = '0;
                                    n_res.crc    = 8'h00;
                                    n_phase      = PH_SYNC;
                                    n_last_code  = '0;
                                    n_state      = FS_RESULT;
                                end else begin
                                    n_len  = b0[LEN_W-1:0];
                                    n_rcrc = b1;
                                    n_fill = '0;
                                    n_crc  = crc_out;
                                    if (b0 == 8'h00) begin
                                        // empty packet
                                        n_res.status = (crc_out == b1) ? STAT_OK : STAT_CRC_FAIL;
                                        n_res.length = '0;
                                        n_res.crc    = crc_out;
                                        n_phase      = PH_SYNC;
                                        n_last_code  = '0;
                                        n_state      = FS_RESULT;
                                    end else begin
                                        n_phase = PH_PAYLOAD;
                                    end
                                end
                            end
                            PH_PAYLOAD: begin
                                n_code  = i_in_item.code;
                                n_sel   = 2'd0;
                                n_state = FS_PAY;
                            end
                            default: begin
                                if (b0 == r_sync_value) begin
                                    n_seq   = b1;
                                    n_kind  = b2;
                                    n_crc   = crc_out;
                                    n_code  = i_in_item.code;
                                    n_phase = PH_HEADER;
                                    n_state = FS_SYNC2;
                                end
                            end
                        endcase
                    end
                end
            end

            // fold in the kind byte
            FS_SYNC2: begin
                n_crc   = crc_out;
                n_state = FS_IDLE;
            end

            // one payload byte per cycle
            FS_PAY: begin
                if (r_fill < len_ext) begin
                    wr_en  = 1'b1;
                    n_crc  = crc_out;
                    n_fill = r_fill + CW'(1);
                end
                n_sel = r_sel + 2'd1;
                if (r_sel == LAST_BYTE) begin
                    n_state = FS_CHECK;
                end
            end

            // frame complete?
            FS_CHECK: begin
                if (r_fill < len_ext) begin
                    n_state = FS_IDLE;
                end else begin
                    n_phase     = PH_SYNC;
                    n_last_code = '0;
                    if (r_crc != r_rcrc) begin
                        n_res.status = STAT_CRC_FAIL;
                        n_res.length = r_len;
                        n_res.crc    = r_crc;
                        n_state      = FS_RESULT;
                    end else begin
                        n_idx   = '0;
                        n_state = FS_READ;
                    end
                end
            end

            // single result
            FS_RESULT: begin
                if (out_free) begin
                    out_load                = 1'b1;
                    n_out_item.status       = r_res.status;
                    n_out_item.seq_number   = r_seq;
                    n_out_item.frame_kind   = r_kind;
                    n_out_item.frame_length = r_res.length;
                    n_out_item.data_byte    = 8'h00;
                    n_out_item.computed_crc = r_res.crc;
                    n_out_item.last_item    = 1'b1;
                    n_state                 = FS_IDLE;
                end
            end

            // payload read-back
            FS_READ: begin
                rd_en   = 1'b1;
                n_state = FS_EMIT;
            end

            FS_EMIT: begin
                if (out_free) begin
                    out_load                = 1'b1;
                    n_out_item.status       = STAT_OK;
                    n_out_item.seq_number   = r_seq;
                    n_out_item.frame_kind   = r_kind;
                    n_out_item.frame_length = r_len;
                    n_out_item.data_byte    = rd_data;
                    n_out_item.computed_crc = r_crc;
                    n_out_item.last_item    = last_out;
                    n_idx                   = r_idx + CW'(1);
                    n_state                 = last_out ? FS_IDLE : FS_READ;
                end
            end

            default: n_state = FS_IDLE;
        endcase
    end

    // Control and frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_IDLE;
            r_phase     <= PH_SYNC;
            r_last_code <= '0;
            r_elapsed   <= '0;
            r_seq       <= '0;
            r_kind      <= '0;
            r_len       <= '0;
            r_rcrc      <= '0;
            r_crc       <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_last_code <= n_last_code;
            r_elapsed   <= n_elapsed;
            r_seq       <= n_seq;
            r_kind      <= n_kind;
            r_len       <= n_len;
            r_rcrc      <= n_rcrc;
            r_crc       <= n_crc;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_sel       <= n_sel;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
            r_timeout    <= TIMEOUT_RESET;
            r_max_len    <= MAXLEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SYNC_VALUE:    r_sync_value <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS: r_timeout    <= i_cfg_data;
                CFG_MAX_LENGTH:    r_max_len    <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ verif/tb_rf_code_packet_deframer.sv @@
// Self-checking testbench for the radio code packet deframer.
`timescale 1ns / 100ps

module tb_rf_code_packet_deframer;
    import rcpd_pkg::*;

    localparam int PAYLOAD_MAX  = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_CAP   = 200;
    // index 3 has no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // Block ports
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data  = '0;

    rf_code_packet_deframer #(
        .MAX_LEN(PAYLOAD_MAX)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Stimulus and scoreboard storage
    t_in_item  code_queue[$];
    t_out_item frame_reports_due[$];
    int        queued_count   = 0;
    int        accepted_count = 0;
    int        codes_queued   = 0;
    int        error_count    = 0;
    int        cycle_count    = 0;
    logic [23:0] last_queued_code = '0;

    // Idle rates and the long receiver hold-off
    int   sender_idle_pct   = 0;
    int   receiver_idle_pct = 0;
    logic hold_request      = 1'b0;
    logic hold_ack          = 1'b0;
    int   hold_left         = 0;

    // Deframer copy: configuration
    logic [7:0]       cfg_sync    = SYNC_RESET;
    logic [15:0]      cfg_timeout = TIMEOUT_RESET;
    logic [LEN_W-1:0] cfg_max_len = MAXLEN_RESET;

    // Deframer copy: frame state
    t_phase           frame_phase = PH_SYNC;
    logic [23:0]      prev_code   = '0;
    logic [15:0]      tick_count  = '0;
    logic [7:0]       frame_seq   = '0;
    logic [7:0]       frame_kind  = '0;
    logic [LEN_W-1:0] frame_len   = '0;
    logic [7:0]       crc_rx      = '0;
    logic [7:0]       crc_run     = '0;
    logic [LEN_W-1:0] fill_count  = '0;
    logic [7:0]       payload_mem [PAYLOAD_MAX];

    // CRC-8, polynomial 0x07, MSB first
    function automatic logic [7:0] crc8_fold(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic int unsigned length_limit();
        return (cfg_max_len < PAYLOAD_MAX) ? cfg_max_len : PAYLOAD_MAX;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_W-1:0] data);
        case (idx)
            CFG_SYNC_VALUE:    cfg_sync    = data[7:0];
            CFG_TIMEOUT_TICKS: cfg_timeout = data;
            CFG_MAX_LENGTH:    cfg_max_len = data[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void report_frame(logic [1:0] status, logic [LEN_W-1:0] len,
                                         logic [7:0] data, logic [7:0] crc,
                                         logic last);
        t_out_item r;
        r.status       = status;
        r.seq_number   = frame_seq;
        r.frame_kind   = frame_kind;
        r.frame_length = len;
        r.data_byte    = data;
        r.computed_crc = crc;
        r.last_item    = last;
        frame_reports_due.push_back(r);
    endfunction

    function automatic void drop_frame();
        frame_phase = PH_SYNC;
        prev_code   = '0;
    endfunction

    // Expected reports for one accepted item
    function automatic void deframe_item(t_in_item it);
        logic [7:0] b0, b1, b2;
        logic [7:0] bytes [3];
        // millisecond tick: count and maybe time out the open frame
        if (it.func) begin
            if (tick_count != 16'hFFFF)
                tick_count++;
            if (frame_phase != PH_SYNC && tick_count > cfg_timeout) begin
                report_frame(STAT_TIMEOUT, (frame_phase == PH_PAYLOAD) ? frame_len : '0,
                             8'h00, 8'h00, 1'b1);
                drop_frame();
            end
            return;
        end
        // zero and repeated codes are dropped
        if (it.code == '0 || it.code == prev_code)
            return;
        prev_code  = it.code;
        tick_count = '0;
        b0 = it.code[23:16];
        b1 = it.code[15:8];
        b2 = it.code[7:0];
        case (frame_phase)
            PH_HEADER: begin
                if (b0 > length_limit()) begin
                    report_frame(STAT_BAD_LEN, '0, 8'h00, 8'h00, 1'b1);
                    drop_frame();
                    return;
                end
                frame_len  = b0[LEN_W-1:0];
                crc_rx     = b1;
                fill_count = '0;
                crc_run    = crc8_fold(crc_run, b0);
                if (b0 == 8'h00) begin
                    report_frame((crc_run == crc_rx) ? STAT_OK : STAT_CRC_FAIL, '0,
                                 8'h00, crc_run, 1'b1);
                    drop_frame();
                end else begin
                    frame_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                bytes[0] = b0;
                bytes[1] = b1;
                bytes[2] = b2;
                for (int j = 0; j < 3; j++) begin
                    if (fill_count < frame_len && fill_count < PAYLOAD_MAX) begin
                        payload_mem[fill_count] = bytes[j];
                        crc_run = crc8_fold(crc_run, bytes[j]);
                        fill_count++;
                    end
                end
                if (fill_count < frame_len)
                    return;
                drop_frame();
                if (crc_run != crc_rx) begin
                    report_frame(STAT_CRC_FAIL, frame_len, 8'h00, crc_run, 1'b1);
                end else begin
                    for (int i = 0; i < frame_len && i < PAYLOAD_MAX; i++)
                        report_frame(STAT_OK, frame_len, payload_mem[i], crc_run,
                                     (i + 1 == frame_len));
                end
            end
            default: begin
                // waiting for sync
                if (b0 == cfg_sync) begin
                    frame_seq   = b1;
                    frame_kind  = b2;
                    crc_run     = crc8_fold(crc8_fold(8'h00, b1), b2);
                    frame_phase = PH_HEADER;
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            if (error_count < REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_report(t_out_item got);
        t_out_item want;
        if (frame_reports_due.size() == 0) begin
            if (error_count < REPORT_CAP)
                $display("%0t: unexpected report, expected none, actual %p", $time, got);
            error_count++;
            return;
        end
        want = frame_reports_due.pop_front();
        check_field("status", want.status, got.status);
        check_field("seq_number", want.seq_number, got.seq_number);
        check_field("frame_kind", want.frame_kind, got.frame_kind);
        check_field("frame_length", want.frame_length, got.frame_length);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("computed_crc", want.computed_crc, got.computed_crc);
        check_field("last_item", want.last_item, got.last_item);
    endfunction

    // Sender: offers the next queued item once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_item  <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                deframe_item(i_in_item);
                accepted_count++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (code_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= code_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks reports and stalls at random or during a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_report(o_out_item);
            i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // Long receiver hold-off, started by a toggle of hold_request
    always @(posedge i_clk) begin
        if (hold_request != hold_ack) begin
            hold_ack  <= hold_request;
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus helpers
    function automatic void queue_code(logic [23:0] c);
        code_queue.push_back({1'b0, c});
        queued_count++;
        codes_queued++;
        last_queued_code = c;
    endfunction

    function automatic void queue_ticks(int n);
        logic [23:0] junk;
        for (int i = 0; i < n; i++) begin
            junk = 24'($urandom_range(0, 24'hFFFFFF));
            code_queue.push_back({1'b1, junk});
            queued_count++;
        end
    endfunction

    // Sync (optionally twice), optional ticks, header, then the payload codes if the length fits
    function automatic void queue_packet(logic [7:0] seq, logic [7:0] kind, int len,
                                         bit bad_crc, int gap_ticks, bit dup_sync);
        logic [7:0] pay [18];
        logic [7:0] crc;
        logic [7:0] junk;
        for (int i = 0; i < 18; i++)
            pay[i] = 8'($urandom_range(0, 255));
        crc = crc8_fold(crc8_fold(8'h00, seq), kind);
        crc = crc8_fold(crc, len[7:0]);
        for (int i = 0; i < len && i < PAYLOAD_MAX; i++)
            crc = crc8_fold(crc, pay[i]);
        if (bad_crc) begin
            junk = 8'($urandom_range(1, 255));
            crc  = crc ^ junk;
        end
        queue_code({cfg_sync, seq, kind});
        if (dup_sync)
            queue_code({cfg_sync, seq, kind});
        queue_ticks(gap_ticks);
        junk = 8'($urandom_range(0, 255));
        queue_code({len[7:0], crc, junk});
        if (len <= length_limit())
            for (int i = 0; i < (len + 2) / 3; i++)
                queue_code({pay[3*i], pay[3*i+1], pay[3*i+2]});
    endfunction

    // Mostly well-formed packets with random content, plus noise
    function automatic void queue_random_traffic(int n_codes);
        int start;
        int pick;
        int len;
        int burst;
        logic [15:0] r16;
        logic [7:0]  r8;
        start = codes_queued;
        while (codes_queued - start < n_codes) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, length_limit())
                                                 : $urandom_range(0, 255);
                queue_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                             $urandom_range(0, 99) < 15, $urandom_range(0, 2),
                             $urandom_range(0, 19) == 0);
            end else if (pick < 80) begin
                burst = cfg_timeout + 3;
                queue_ticks($urandom_range(1, (burst > 40) ? 40 : burst));
            end else if (pick < 88) begin
                // truncated frame: the next sync lands in the payload
                r16 = 16'($urandom);
                queue_code({cfg_sync, r16});
                r16 = 16'($urandom);
                r8  = 8'($urandom_range(1, 16));
                queue_code({r8, r16});
            end else if (pick < 94) begin
                queue_code(($urandom_range(0, 1) != 0) ? last_queued_code : 24'h000000);
            end else begin
                queue_code(24'($urandom_range(0, 24'hFFFFFF)));
            end
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sender pause: everything taken and reported, then let the block settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (accepted_count != queued_count || frame_reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(int sender_pct, int receiver_pct);
        sender_idle_pct   <= sender_pct;
        receiver_idle_pct <= receiver_pct;
        @(posedge i_clk);
    endtask

    // Test sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset configuration: ignored items, empty and full packets
        set_idling(22, 72);
        queue_code(24'h000000);
        code_queue.push_back({1'b1, 24'hFFFFFF});
        queued_count++;
        queue_packet(8'hFF, 8'h00, 0, 1'b0, 0, 1'b0);
        queue_packet(8'h00, 8'hFF, 0, 1'b1, 0, 1'b0);
        queue_packet(8'h12, 8'h34, 16, 1'b0, 0, 1'b1);
        queue_packet(8'h56, 8'h78, 3, 1'b1, 0, 1'b0);
        wait_idle();

        // Directed: sync 0, first tick times out, only length 0 accepted
        write_reg(CFG_SYNC_VALUE, 16'hFF00);
        write_reg(CFG_TIMEOUT_TICKS, 16'h0000);
        write_reg(CFG_MAX_LENGTH, 16'h0000);
        queue_code(24'h005AA5);
        queue_ticks(1);
        queue_packet(8'h01, 8'h02, 1, 1'b0, 0, 1'b0);
        queue_packet(8'h03, 8'h04, 0, 1'b0, 0, 1'b0);
        wait_idle();

        // Directed: timeout in the payload, length above the limit
        write_reg(CFG_SYNC_VALUE, 16'hFFFF);
        write_reg(CFG_TIMEOUT_TICKS, 16'h0001);
        write_reg(CFG_MAX_LENGTH, 16'hFFFF);
        write_reg(CFG_IDX_SPARE, 16'($urandom_range(0, 16'hFFFF)));
        queue_code(24'hFF9ABC);
        queue_code(24'h0500FF);
        queue_code(24'h123456);
        queue_ticks(2);
        queue_packet(8'hC3, 8'h3C, 17, 1'b0, 0, 1'b0);
        wait_idle();

        // Random, slow receiver, with a long hold-off over full packets
        write_reg(CFG_SYNC_VALUE, 16'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(3, 20)));
        write_reg(CFG_MAX_LENGTH, 16'd16);
        for (int i = 0; i < 3; i++)
            queue_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16,
                         1'b0, 0, 1'b0);
        hold_request <= ~hold_request;
        queue_random_traffic(10);
        wait_idle();

        // Random, slow sender, shorter length limit
        set_idling(72, 22);
        write_reg(CFG_SYNC_VALUE, 16'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(3, 20)));
        write_reg(CFG_MAX_LENGTH, 16'($urandom_range(1, 15)));
        queue_random_traffic(10);
        wait_idle();

        // No idling: largest timeout never fires
        set_idling(0, 0);
        write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
        write_reg(CFG_MAX_LENGTH, 16'd16);
        queue_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 0, 1'b0, 5, 1'b0);
        wait_idle();

        write_reg(CFG_SYNC_VALUE, 16'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(3, 20)));
        queue_random_traffic(10);
        wait_idle();

        if (error_count == 0 && frame_reports_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ rf_code_packet_deframer.f @@
rtl/rcpd_pkg.sv
rtl/rcpd_payload_mem.sv
rtl/rf_code_packet_deframer.sv
verif/tb_rf_code_packet_deframer.sv
